// ===== rtl/spc_pkg.sv =====
// spc_pkg: shared types, constants and fixed-point helpers for the skeleton pose composer
// no dependencies
package spc_pkg;

   localparam int MAX_BONES_DEF = 256;
   localparam int WORD_W = 32;
   localparam int PROD_W = 64;
   localparam int ACC_W = 52;
   localparam logic signed [WORD_W-1:0] ONE_Q16 = 32'sd65536;
   localparam logic signed [ACC_W-1:0] SAT_MAX = 52'sd2147483647;
   localparam logic signed [ACC_W-1:0] SAT_MIN = -52'sd2147483648;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_QUAT,
      ST_ROT,
      ST_PROD,
      ST_SEND
   } state_type;

   // rounded Q16.16 product, floor after adding half
   function automatic logic signed [ACC_W-1:0] round_q16(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] t;
      t = (p + 64'sd32768) >>> 16;
      return t[ACC_W-1:0];
   endfunction

   function automatic logic signed [WORD_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
      logic signed [WORD_W-1:0] r;
      if (v > SAT_MAX) begin
         r = SAT_MAX[WORD_W-1:0];
      end else if (v < SAT_MIN) begin
         r = SAT_MIN[WORD_W-1:0];
      end else begin
         r = v[WORD_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== rtl/spc_req_if.sv =====
// spc_req_if: bone item channel with valid/ready handshake
// no dependencies
interface spc_req_if;
   logic valid;
   logic ready;
   logic [7:0] bone_slot;
   logic [7:0] parent_slot;
   logic is_root;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;
   logic signed [31:0] rot_w;
   logic signed [31:0] rot_x;
   logic signed [31:0] rot_y;
   logic signed [31:0] rot_z;
   modport source (output valid, bone_slot, parent_slot, is_root, pos_x, pos_y, pos_z,
      rot_w, rot_x, rot_y, rot_z, input ready);
   modport sink (input valid, bone_slot, parent_slot, is_root, pos_x, pos_y, pos_z,
      rot_w, rot_x, rot_y, rot_z, output ready);
endinterface

// ===== rtl/spc_rsp_if.sv =====
// spc_rsp_if: matrix column channel with valid/ready handshake
// no dependencies
interface spc_rsp_if;
   logic valid;
   logic ready;
   logic [7:0] out_slot;
   logic [1:0] column_index;
   logic signed [31:0] elem_row0;
   logic signed [31:0] elem_row1;
   logic signed [31:0] elem_row2;
   logic signed [31:0] elem_row3;
   logic last_column;
   modport source (output valid, out_slot, column_index, elem_row0, elem_row1, elem_row2,
      elem_row3, last_column, input ready);
   modport sink (input valid, out_slot, column_index, elem_row0, elem_row1, elem_row2,
      elem_row3, last_column, output ready);
endinterface

// ===== rtl/spc_mac.sv =====
// spc_mac: shared registered 32x32 multiplier with Q16.16 rounding
// depends on spc_pkg
module spc_mac
   import spc_pkg::*;
(
   input  logic                     clock,
   input  logic signed [WORD_W-1:0] op_a,
   input  logic signed [WORD_W-1:0] op_b,
   output logic signed [ACC_W-1:0]  prod
);
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = PROD_W'(op_a) * PROD_W'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = round_q16(prod_ff);
endmodule

// ===== rtl/spc_store.sv =====
// spc_store: bone matrix memory, one word per entry, registered read
// depends on spc_pkg
module spc_store
   import spc_pkg::*;
#(
   parameter int MAX_BONES = MAX_BONES_DEF
) (
   input  logic                               clock,
   input  logic                               wr_en,
   input  logic [$clog2(MAX_BONES*16)-1:0]    wr_addr,
   input  logic signed [WORD_W-1:0]           wr_data,
   input  logic [$clog2(MAX_BONES*16)-1:0]    rd_addr,
   output logic signed [WORD_W-1:0]           rd_data
);
   logic signed [WORD_W-1:0] mem [MAX_BONES*16];
   logic signed [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/skeleton_pose_composer_core.sv =====
// skeleton_pose_composer_core: one bone per item, quaternion to matrix, parent product
// depends on spc_pkg, spc_req_if, spc_rsp_if, spc_mac, spc_store
// steps: quaternion products in ST_QUAT, rotation in ST_ROT, then for a child
// the parent product in ST_PROD on the one multiplier; ST_SEND writes back, then sends;
// a new item is taken only in ST_IDLE, once the last column has been taken;
// four column items follow, each held until taken; reset (synchronous) clears control
module skeleton_pose_composer_core
   import spc_pkg::*;
#(
   parameter int MAX_BONES = MAX_BONES_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_write_enable,
   input  logic          csr_write_data,
   spc_req_if.sink       req,
   spc_rsp_if.source     rsp
);
   localparam int AW = $clog2(MAX_BONES*16);
   localparam int SW = $clog2(MAX_BONES);

   state_type state_ff, state_in;
   logic mode_ff;
   logic [6:0] step_ff, step_in;
   logic [7:0] slot_ff;
   logic [SW-1:0] bidx_ff;
   logic [SW-1:0] par_ff;
   logic root_ff;
   logic signed [WORD_W-1:0] q_ff [7];   // px py pz w x y z
   logic signed [ACC_W-1:0] pr_ff [9];   // xx yy zz xy xz yz wx wy wz
   logic signed [WORD_W-1:0] loc_ff [16];
   logic signed [WORD_W-1:0] res_ff [16];
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [WORD_W-1:0] pel_ff;
   logic [1:0] col_ff;

   logic signed [WORD_W-1:0] op_a, op_b;
   logic signed [ACC_W-1:0] prod;
   logic wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic signed [WORD_W-1:0] wr_data, rd_data;

   spc_mac u_mac (.clock(clock), .op_a(op_a), .op_b(op_b), .prod(prod));
   spc_store #(.MAX_BONES(MAX_BONES)) u_store (.clock(clock), .wr_en(wr_en),
      .wr_addr(wr_addr), .wr_data(wr_data), .rd_addr(rd_addr), .rd_data(rd_data));

   // quaternion product table, index 0..8
   function automatic logic [5:0] qsel(input logic [3:0] i);
      logic [5:0] r;
      case (i)
         4'd0: r = {3'd4, 3'd4};
         4'd1: r = {3'd5, 3'd5};
         4'd2: r = {3'd6, 3'd6};
         4'd3: r = {3'd4, 3'd5};
         4'd4: r = {3'd4, 3'd6};
         4'd5: r = {3'd5, 3'd6};
         4'd6: r = {3'd3, 3'd4};
         4'd7: r = {3'd3, 3'd5};
         default: r = {3'd3, 3'd6};
      endcase
      return r;
   endfunction

   function automatic logic signed [WORD_W-1:0] diag(input logic signed [ACC_W-1:0] a,
      input logic signed [ACC_W-1:0] b);
      return sat32(ACC_W'(ONE_Q16) - ((a + b) <<< 1));
   endfunction

   function automatic logic signed [WORD_W-1:0] offd(input logic signed [ACC_W-1:0] v);
      return sat32(v <<< 1);
   endfunction

   // slot modulo the bone count by shifted compare and subtract
   function automatic logic [7:0] slot_mod(input logic [7:0] v);
      logic [23:0] r;
      r = {16'd0, v};
      for (int j = 7; j >= 0; j--) begin
         if (r >= (24'(MAX_BONES) << j)) begin
            r = r - (24'(MAX_BONES) << j);
         end
      end
      return r[7:0];
   endfunction

   // child product step: step = c*16 + r*4 + k, operands reach the mac via the store read register and pel_ff
   logic [3:0] qi;
   logic [5:0] qs;
   logic [1:0] pr, pk;
   logic [5:0] pstep;
   logic [5:0] dstep;
   logic [5:0] estep;
   assign qi = step_ff[3:0];
   assign qs = qsel(qi);
   assign pstep = step_ff[5:0];
   assign pr = pstep[3:2];
   assign pk = pstep[1:0];
   assign dstep = pstep - 6'd2;
   assign estep = pstep - 6'd3;

   always_comb begin
      op_a = q_ff[qs[5:3]];
      op_b = q_ff[qs[2:0]];
      if (state_ff == ST_PROD) begin
         op_a = pel_ff;
         op_b = loc_ff[{dstep[5:4], dstep[1:0]}];
      end
   end

   // parent read address: element k*4+r of the parent, issued at step
   assign rd_addr = AW'({par_ff, pk, pr});
   assign wr_en = (state_ff == ST_SEND) && (step_ff[6:4] == 3'd0);
   assign wr_addr = AW'({bidx_ff, step_ff[3:0]});
   assign wr_data = res_ff[step_ff[3:0]];

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               state_in = ST_QUAT;
               step_in = '0;
            end
         end
         ST_QUAT: begin
            step_in = step_ff + 7'd1;
            if (step_ff == 7'd9) begin
               state_in = ST_ROT;
            end
         end
         ST_ROT: begin
            step_in = '0;
            state_in = root_ff ? ST_SEND : ST_PROD;
         end
         ST_PROD: begin
            step_in = step_ff + 7'd1;
            if (step_ff == 7'd66) begin
               state_in = ST_SEND;
               step_in = '0;
            end
         end
         ST_SEND: begin
            if (step_ff[6:4] == 3'd0) begin
               step_in = step_ff + 7'd1;
            end else if (rsp.ready) begin
               if (col_ff == 2'd3) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = (state_ff == ST_SEND) && (step_ff[6:4] != 3'd0);
   assign rsp.out_slot = slot_ff;
   assign rsp.column_index = col_ff;
   assign rsp.elem_row0 = res_ff[{col_ff, 2'd0}];
   assign rsp.elem_row1 = res_ff[{col_ff, 2'd1}];
   assign rsp.elem_row2 = res_ff[{col_ff, 2'd2}];
   assign rsp.elem_row3 = res_ff[{col_ff, 2'd3}];
   assign rsp.last_column = (col_ff == 2'd3);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mode_ff <= 1'b0;
         step_ff <= '0;
         col_ff <= '0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         if (csr_write_enable) begin
            mode_ff <= csr_write_data;
         end
         if (state_ff == ST_IDLE) begin
            col_ff <= '0;
         end else if (rsp.valid && rsp.ready) begin
            col_ff <= col_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         slot_ff <= req.bone_slot;
         bidx_ff <= SW'(slot_mod(req.bone_slot));
         par_ff <= SW'(slot_mod(req.parent_slot));
         root_ff <= req.is_root;
         q_ff[0] <= req.pos_x;
         q_ff[1] <= req.pos_y;
         q_ff[2] <= req.pos_z;
         q_ff[3] <= req.rot_w;
         q_ff[4] <= req.rot_x;
         q_ff[5] <= req.rot_y;
         q_ff[6] <= req.rot_z;
      end
      if (state_ff == ST_QUAT && step_ff != 7'd0) begin
         pr_ff[step_ff[3:0] - 4'd1] <= prod;
      end
      if (state_ff == ST_ROT) begin
         loc_ff[0] <= diag(pr_ff[1], pr_ff[2]);
         loc_ff[1] <= offd(pr_ff[3] + pr_ff[8]);
         loc_ff[2] <= offd(pr_ff[4] - pr_ff[7]);
         loc_ff[3] <= '0;
         loc_ff[4] <= offd(pr_ff[3] - pr_ff[8]);
         loc_ff[5] <= diag(pr_ff[0], pr_ff[2]);
         loc_ff[6] <= offd(pr_ff[5] + pr_ff[6]);
         loc_ff[7] <= '0;
         loc_ff[8] <= offd(pr_ff[4] + pr_ff[7]);
         loc_ff[9] <= offd(pr_ff[5] - pr_ff[6]);
         loc_ff[10] <= diag(pr_ff[0], pr_ff[1]);
         loc_ff[11] <= '0;
         loc_ff[12] <= (mode_ff || !root_ff) ? q_ff[0] : '0;
         loc_ff[13] <= (mode_ff || !root_ff) ? q_ff[1] : '0;
         loc_ff[14] <= (mode_ff || !root_ff) ? q_ff[2] : '0;
         loc_ff[15] <= ONE_Q16;
         res_ff[0] <= diag(pr_ff[1], pr_ff[2]);
         res_ff[1] <= offd(pr_ff[3] + pr_ff[8]);
         res_ff[2] <= offd(pr_ff[4] - pr_ff[7]);
         res_ff[3] <= '0;
         res_ff[4] <= offd(pr_ff[3] - pr_ff[8]);
         res_ff[5] <= diag(pr_ff[0], pr_ff[2]);
         res_ff[6] <= offd(pr_ff[5] + pr_ff[6]);
         res_ff[7] <= '0;
         res_ff[8] <= offd(pr_ff[4] + pr_ff[7]);
         res_ff[9] <= offd(pr_ff[5] - pr_ff[6]);
         res_ff[10] <= diag(pr_ff[0], pr_ff[1]);
         res_ff[11] <= '0;
         res_ff[12] <= mode_ff ? q_ff[0] : '0;
         res_ff[13] <= mode_ff ? q_ff[1] : '0;
         res_ff[14] <= mode_ff ? q_ff[2] : '0;
         res_ff[15] <= ONE_Q16;
      end
      // read issued at a step, data in the store read register, operands from pel_ff, product from the mac register
      if (state_ff == ST_PROD) begin
         pel_ff <= rd_data;
         if (step_ff >= 7'd3) begin
            if (estep[1:0] == 2'd0) begin
               acc_ff <= prod;
            end else begin
               acc_ff <= acc_ff + prod;
            end
            if (estep[1:0] == 2'd3) begin
               res_ff[estep[5:2]] <= sat32(acc_ff + prod);
            end
         end
      end
   end
endmodule

// ===== rtl/spc_checker.sv =====
// spc_checker: port-level assertions for the skeleton pose composer
// depends on skeleton_pose_composer_core ports
module spc_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [1:0] rsp_column_index,
   input logic rsp_last_column
);
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_column == (rsp_column_index == 2'd3)))
      else $error("last column flag mismatch");
   a_noacc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input accepted during output");
   a_col: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last_column) |=> (rsp_valid &&
      rsp_column_index == $past(rsp_column_index) + 2'd1))
      else $error("column order broken");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_column_index)))
      else $error("stalled item dropped");
endmodule

bind skeleton_pose_composer_core spc_checker u_spc_checker (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_column_index(rsp.column_index),
   .rsp_last_column(rsp.last_column));
